>>> src/i2c_bit_level_master_unit_assert.svh
// Assertion macros used by the I2C bit engine sequencer.
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_ASSERT_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define I2CBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define I2CBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/i2cbm_pkg.sv
// Types, command codes and microprogram of the I2C bit engine.
`timescale 1ns / 1ps

package i2cbm_pkg;

  localparam int PC_W   = 5;
  localparam int HOLD_W = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd720;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [2:0] LAST_BIT = 3'd7;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_STOP    = 3'd1;
  localparam logic [2:0] KIND_TX_BYTE = 3'd2;
  localparam logic [2:0] KIND_RX_BYTE = 3'd3;
  localparam logic [2:0] KIND_TX_ACK  = 3'd4;
  localparam logic [2:0] KIND_RX_ACK  = 3'd5;

  localparam logic REG_HOLD_CYCLES = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    LV_LOW,
    LV_HIGH,
    LV_TX_BIT,
    LV_ACK
  } lvl_t;

  typedef enum logic [1:0] {
    SQ_NEXT,
    SQ_LOOP,
    SQ_DONE
  } seq_t;

  typedef struct packed {
    logic            scl;
    lvl_t            lvl;
    seq_t            seq;
    logic [PC_W-1:0] tgt;
  } uword_t;

  typedef struct packed {
    logic load;
    logic fire;
    logic shift;
    logic scl;
    lvl_t lvl;
    logic last;
  } ctl_t;

  localparam logic [PC_W-1:0] PC_START   = 5'd0;
  localparam logic [PC_W-1:0] PC_STOP    = 5'd4;
  localparam logic [PC_W-1:0] PC_TX_BYTE = 5'd7;
  localparam logic [PC_W-1:0] PC_RX_BYTE = 5'd10;
  localparam logic [PC_W-1:0] PC_RX_BIT  = 5'd11;
  localparam logic [PC_W-1:0] PC_TX_ACK  = 5'd13;
  localparam logic [PC_W-1:0] PC_RX_ACK  = 5'd16;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{scl: 1'b0, lvl: LV_HIGH, seq: SQ_DONE, tgt: '0};
    case (pc)
      5'd0:  w = '{scl: 1'b0, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd1:  w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd2:  w = '{scl: 1'b0, lvl: LV_LOW,    seq: SQ_NEXT, tgt: '0};
      5'd3:  w = '{scl: 1'b1, lvl: LV_LOW,    seq: SQ_DONE, tgt: '0};
      5'd4:  w = '{scl: 1'b0, lvl: LV_LOW,    seq: SQ_NEXT, tgt: '0};
      5'd5:  w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd6:  w = '{scl: 1'b0, lvl: LV_HIGH,   seq: SQ_DONE, tgt: '0};
      5'd7:  w = '{scl: 1'b0, lvl: LV_TX_BIT, seq: SQ_NEXT, tgt: '0};
      5'd8:  w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd9:  w = '{scl: 1'b1, lvl: LV_LOW,    seq: SQ_LOOP, tgt: PC_TX_BYTE};
      5'd10: w = '{scl: 1'b0, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd11: w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd12: w = '{scl: 1'b1, lvl: LV_LOW,    seq: SQ_LOOP, tgt: PC_RX_BIT};
      5'd13: w = '{scl: 1'b0, lvl: LV_ACK,    seq: SQ_NEXT, tgt: '0};
      5'd14: w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd15: w = '{scl: 1'b1, lvl: LV_LOW,    seq: SQ_DONE, tgt: '0};
      5'd16: w = '{scl: 1'b0, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd17: w = '{scl: 1'b1, lvl: LV_HIGH,   seq: SQ_NEXT, tgt: '0};
      5'd18: w = '{scl: 1'b1, lvl: LV_LOW,    seq: SQ_DONE, tgt: '0};
      default: w = '{scl: 1'b0, lvl: LV_HIGH, seq: SQ_DONE, tgt: '0};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
    logic [PC_W-1:0] pc;
    pc = PC_START;
    case (kind)
      KIND_START:   pc = PC_START;
      KIND_STOP:    pc = PC_STOP;
      KIND_TX_BYTE: pc = PC_TX_BYTE;
      KIND_RX_BYTE: pc = PC_RX_BYTE;
      KIND_TX_ACK:  pc = PC_TX_ACK;
      KIND_RX_ACK:  pc = PC_RX_ACK;
      default:      pc = PC_START;
    endcase
    return pc;
  endfunction

endpackage

>>> src/i2cbm_useq.sv
// Microprogram sequencer: step counter, bit loop counter and hold timer.
`timescale 1ns / 1ps
`include "i2c_bit_level_master_unit_assert.svh"

module i2cbm_useq import i2cbm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_kind,
  output logic              in_stall,
  input  logic              out_free,
  input  logic [HOLD_W-1:0] hold_cycles,
  output ctl_t              ctl
);

  state_t            state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [2:0]        bits_r, bits_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              done_r, done_nxt;
  uword_t            uw;
  logic              kind_ok;
  logic              step_last;

  assign uw        = ucode(pc_r);
  assign kind_ok   = in_kind inside {[KIND_START:KIND_RX_ACK]};
  assign step_last = (uw.seq == SQ_DONE) || ((uw.seq == SQ_LOOP) && (bits_r == LAST_BIT));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && kind_ok) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (hold_r == '0) state_nxt = done_r ? ST_IDLE : ST_EXEC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    ctl       = '{load: 1'b0, fire: 1'b0, shift: 1'b0, scl: uw.scl, lvl: uw.lvl,
                  last: step_last};
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid && kind_ok;
      end
      ST_EXEC: begin
        ctl.fire  = out_free;
        ctl.shift = out_free && (uw.seq == SQ_LOOP);
      end
      ST_HOLD: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    bits_nxt = bits_r;
    hold_nxt = hold_r;
    done_nxt = done_r;
    if (ctl.load) begin
      pc_nxt   = entry_pc(in_kind);
      bits_nxt = '0;
    end else if (ctl.fire) begin
      hold_nxt = hold_cycles;
      done_nxt = step_last;
      if (uw.seq == SQ_LOOP && !step_last) begin
        pc_nxt   = uw.tgt;
        bits_nxt = bits_r + 3'd1;
      end else begin
        pc_nxt = pc_r + 5'd1;
      end
    end else if (state_r == ST_HOLD && hold_r != '0) begin
      hold_nxt = hold_r - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      bits_r  <= '0;
      hold_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      bits_r  <= bits_nxt;
      hold_r  <= hold_nxt;
      done_r  <= done_nxt;
    end
  end

  `I2CBM_ASSERT_NEXT(a_last_ends, ctl.fire && ctl.last, state_r == ST_HOLD && done_r, "final step did not mark the command done")
  `I2CBM_ASSERT_NEXT(a_hold_counts, state_r == ST_HOLD && hold_r != '0, state_r == ST_HOLD && hold_r == $past(hold_r) - 16'd1, "hold timer did not count down")
  `I2CBM_ASSERT_NEXT(a_load_starts, ctl.load, state_r == ST_EXEC && bits_r == '0, "accepted command did not start at its entry step")
  `I2CBM_ASSERT_NOW(a_fire_exec, ctl.fire, state_r == ST_EXEC && !ctl.load, "line change issued outside an execute step")

endmodule

>>> src/i2cbm_dpath.sv
// Datapath: line levels, transmit shifter, received value and output word register.
`timescale 1ns / 1ps

module i2cbm_dpath import i2cbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_t       ctl,
  input  logic [2:0] in_kind,
  input  logic [7:0] in_tx_byte,
  input  logic       in_ack_out,
  input  logic [7:0] in_sda_samples,
  output logic       out_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_last,
  output logic [7:0] out_read_value
);

  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] tx_r;
  logic       ack_r;
  logic [7:0] rd_r;
  logic       out_scl_r, out_sda_r, out_last_r;
  logic [7:0] out_rd_r;
  logic       level;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    level = 1'b1;
    case (ctl.lvl)
      LV_LOW:    level = 1'b0;
      LV_HIGH:   level = 1'b1;
      LV_TX_BIT: level = tx_r[7];
      LV_ACK:    level = ack_r;
      default:   level = 1'b1;
    endcase
  end

  always_comb begin
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    out_valid_nxt = out_valid_r;
    if (ctl.fire) begin
      if (ctl.scl) scl_nxt = level;
      else sda_nxt = level;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      tx_r  <= in_tx_byte;
      ack_r <= in_ack_out;
      case (in_kind)
        KIND_RX_BYTE: rd_r <= in_sda_samples;
        KIND_RX_ACK:  rd_r <= {7'd0, in_sda_samples[7]};
        default:      rd_r <= 8'd0;
      endcase
    end else if (ctl.shift) begin
      tx_r <= {tx_r[6:0], 1'b0};
    end
    if (ctl.fire) begin
      out_scl_r  <= scl_nxt;
      out_sda_r  <= sda_nxt;
      out_last_r <= ctl.last;
      out_rd_r   <= ctl.last ? rd_r : 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = out_scl_r;
  assign out_sda_level  = out_sda_r;
  assign out_last       = out_last_r;
  assign out_read_value = out_rd_r;

endmodule

>>> src/i2c_bit_level_master_unit.sv
// Top level of the I2C master bit engine with its configuration register.
//
// One command word enters on the in_ channel (start, stop, send byte, receive
// byte, send ack, receive ack); kinds 6 and 7 are taken and dropped. The block
// then emits one word on the out_ channel for every write of SCL or SDA,
// carrying both line levels after that write, with out_last on the final one
// and the received byte or ack bit in out_read_value there.
// Each line change is made in the execute state and then held in the hold
// state while the sequencer's hold counter counts hold_cycles down to zero;
// a command makes 3 to 24 changes. After a command is taken the sequencer
// enters the execute state, from which the first word is loaded into the
// output word register.
// A new command is taken only once the previous one has finished its last
// hold. If the receiver stalls, the output word register holds its word and
// the sequencer waits before the next line change; nothing is lost.
// After reset both line levels in the datapath are high, hold_cycles is 720 and the block is idle.
// hold_cycles is register 0 on the APB port, at byte address 0.
`timescale 1ns / 1ps

module i2c_bit_level_master_unit import i2cbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  input  logic [7:0]            in_tx_byte,
  input  logic                  in_ack_out,
  input  logic [7:0]            in_sda_samples,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl_level,
  output logic                  out_sda_level,
  output logic                  out_last,
  output logic [7:0]            out_read_value,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [HOLD_W-1:0] hold_cycles_r, hold_cycles_nxt;
  ctl_t              ctl;
  logic              out_free;

  assign pready = 1'b1;

  always_comb begin
    hold_cycles_nxt = hold_cycles_r;
    if (psel && penable && pwrite && paddr[2] == REG_HOLD_CYCLES) begin
      hold_cycles_nxt = pwdata[HOLD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles_r <= HOLD_RESET;
    end else begin
      hold_cycles_r <= hold_cycles_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HOLD_CYCLES) begin
      prdata = {{(CFG_DATA_W-HOLD_W){1'b0}}, hold_cycles_r};
    end
  end

  i2cbm_useq u_useq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_kind     (in_kind),
    .in_stall    (in_stall),
    .out_free    (out_free),
    .hold_cycles (hold_cycles_r),
    .ctl         (ctl)
  );

  i2cbm_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_kind        (in_kind),
    .in_tx_byte     (in_tx_byte),
    .in_ack_out     (in_ack_out),
    .in_sda_samples (in_sda_samples),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_last       (out_last),
    .out_read_value (out_read_value)
  );

endmodule

>>> dv/i2c_bit_level_master_unit_tb.sv
// Self-checking testbench for the I2C master bit engine: command words in, line-level words out.
`timescale 1ns / 1ps

module i2c_bit_level_master_unit_tb;
  import i2cbm_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_CMDS = 80;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_MARGIN = 8;
  localparam longint TIMEOUT_NS = 64'd10_000_000;
  localparam int NUM_ROWS = 24;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam bit LINE_SDA = 1'b0;
  localparam bit LINE_SCL = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] HOLD_ADDR = {REG_HOLD_CYCLES, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx;
    logic       ack;
    logic [7:0] samples;
  } cmd_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       last;
    logic [7:0] rv;
  } line_word_t;

  typedef struct packed {
    logic        new_hold;
    logic [15:0] hold;
    cmd_t        cmd;
    logic        typed;
    logic        scl;
    logic        sda;
    logic [7:0]  rv;
  } plan_row_t;

  // Rows marked typed carry the final word of the command as written out by hand.
  localparam plan_row_t DIRECTED_PLAN [NUM_ROWS] = '{
    '{1'b0, 16'd0,     '{KIND_START,     8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_BYTE,   8'hFF, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b1, 8'h00},
    '{1'b0, 16'd0,     '{KIND_RX_ACK,    8'h00, 1'b0, 8'h80}, 1'b1, 1'b0, 1'b1, 8'h01},
    '{1'b0, 16'd0,     '{KIND_STOP,      8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00},
    '{1'b1, 16'hFFFF,  '{KIND_STOP,      8'hFF, 1'b1, 8'hFF}, 1'b1, 1'b1, 1'b1, 8'h00},
    '{1'b1, 16'd0,     '{KIND_UNUSED_LO, 8'hFF, 1'b1, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_UNUSED_HI, 8'hFF, 1'b1, 8'hFF}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_START,     8'h5A, 1'b1, 8'hA5}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_BYTE,   8'h00, 1'b1, 8'hFF}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_BYTE,   8'hA5, 1'b0, 8'h00}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_BYTE,   8'h5A, 1'b0, 8'h00}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_RX_ACK,    8'h00, 1'b0, 8'h7F}, 1'b1, 1'b0, 1'b1, 8'h00},
    '{1'b0, 16'd0,     '{KIND_RX_BYTE,   8'h00, 1'b0, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'hFF},
    '{1'b0, 16'd0,     '{KIND_RX_BYTE,   8'hFF, 1'b1, 8'h00}, 1'b1, 1'b0, 1'b1, 8'h00},
    '{1'b0, 16'd0,     '{KIND_RX_BYTE,   8'hFF, 1'b1, 8'h96}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_ACK,    8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_ACK,    8'h00, 1'b1, 8'h00}, 1'b1, 1'b0, 1'b1, 8'h00},
    '{1'b0, 16'd0,     '{KIND_RX_ACK,    8'h00, 1'b0, 8'hFF}, 1'b1, 1'b0, 1'b1, 8'h01},
    '{1'b0, 16'd0,     '{KIND_START,     8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_STOP,      8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00},
    '{1'b0, 16'd0,     '{KIND_STOP,      8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00},
    '{1'b1, 16'd1,     '{KIND_START,     8'h00, 1'b0, 8'h00}, 1'b1, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_TX_BYTE,   8'h3C, 1'b0, 8'hC3}, 1'b0, 1'b0, 1'b0, 8'h00},
    '{1'b0, 16'd0,     '{KIND_STOP,      8'h00, 1'b0, 8'h00}, 1'b1, 1'b1, 1'b1, 8'h00}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            in_kind;
  logic [7:0]            in_tx_byte;
  logic                  in_ack_out;
  logic [7:0]            in_sda_samples;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_scl_level;
  logic                  out_sda_level;
  logic                  out_last;
  logic [7:0]            out_read_value;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  line_word_t        line_word_q [$];
  logic              scl_now;
  logic              sda_now;
  logic [HOLD_W-1:0] cur_hold;
  int                mismatches;
  int                cmds_taken;
  bit                rx_hold_req;
  bit                quiet;

  i2c_bit_level_master_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_tx_byte     (in_tx_byte),
    .in_ack_out     (in_ack_out),
    .in_sda_samples (in_sda_samples),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_scl_level  (out_scl_level),
    .out_sda_level  (out_sda_level),
    .out_last       (out_last),
    .out_read_value (out_read_value),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic void push_line(input bit line, input logic lvl);
    if (line == LINE_SCL) scl_now = lvl;
    else sda_now = lvl;
    line_word_q.push_back('{scl: scl_now, sda: sda_now, last: 1'b0, rv: 8'h00});
  endfunction

  function automatic void predict_line_writes(input cmd_t c);
    logic [7:0] rv;
    line_word_t w;
    int         i;
    bit         known;
    rv = 8'h00;
    known = 1'b1;
    case (c.kind)
      KIND_START: begin
        push_line(LINE_SDA, 1'b1);
        push_line(LINE_SCL, 1'b1);
        push_line(LINE_SDA, 1'b0);
        push_line(LINE_SCL, 1'b0);
      end
      KIND_STOP: begin
        push_line(LINE_SDA, 1'b0);
        push_line(LINE_SCL, 1'b1);
        push_line(LINE_SDA, 1'b1);
      end
      KIND_TX_BYTE: begin
        for (i = 7; i >= 0; i--) begin
          push_line(LINE_SDA, c.tx[i]);
          push_line(LINE_SCL, 1'b1);
          push_line(LINE_SCL, 1'b0);
        end
      end
      KIND_RX_BYTE: begin
        push_line(LINE_SDA, 1'b1);
        for (i = 0; i < 8; i++) begin
          push_line(LINE_SCL, 1'b1);
          push_line(LINE_SCL, 1'b0);
        end
        rv = c.samples;
      end
      KIND_TX_ACK: begin
        push_line(LINE_SDA, c.ack);
        push_line(LINE_SCL, 1'b1);
        push_line(LINE_SCL, 1'b0);
      end
      KIND_RX_ACK: begin
        push_line(LINE_SDA, 1'b1);
        push_line(LINE_SCL, 1'b1);
        push_line(LINE_SCL, 1'b0);
        rv = {7'b0, c.samples[7]};
      end
      default: known = 1'b0;
    endcase
    if (known) begin
      w = line_word_q.pop_back();
      w.last = 1'b1;
      w.rv = rv;
      line_word_q.push_back(w);
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic cmd_t rand_cmd(input logic [2:0] kind);
    cmd_t c;
    c.kind = kind;
    c.tx = 8'($urandom);
    c.ack = 1'($urandom);
    c.samples = 8'($urandom);
    return c;
  endfunction

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 13);
  endfunction

  task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_hold_readback();
    logic [CFG_DATA_W-1:0] rdata;
    apb_xfer(1'b0, HOLD_ADDR, '0, rdata);
    if (rdata !== CFG_DATA_W'(cur_hold)) begin
      $display("%0t: hold_cycles read back %0h, expected %0h", $time, rdata, cur_hold);
      mismatches++;
    end
  endtask

  task automatic program_hold(input logic [HOLD_W-1:0] value);
    logic [CFG_DATA_W-1:0] rdata;
    apb_xfer(1'b1, HOLD_ADDR, CFG_DATA_W'(value), rdata);
    cur_hold = value;
    check_hold_readback();
  endtask

  // Called at a falling edge; waits until every expected word has come and the final
  // hold has run out.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (line_word_q.size() != 0) @(posedge clk);
    repeat (int'(cur_hold) + SETTLE_MARGIN) @(posedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic issue_cmd(input cmd_t c, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind <= c.kind;
    in_tx_byte <= c.tx;
    in_ack_out <= c.ack;
    in_sda_samples <= c.samples;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_line_writes(c);
    if (c.kind <= KIND_RX_ACK) cmds_taken++;
    @(negedge clk);
  endtask

  task automatic run_bus_transfer();
    cmd_t c;
    logic rd;
    c = rand_cmd(KIND_TX_BYTE);
    rd = c.tx[0];
    issue_cmd(rand_cmd(KIND_START), pick_gap());
    issue_cmd(c, pick_gap());
    issue_cmd(rand_cmd(KIND_RX_ACK), pick_gap());
    repeat ($urandom_range(1, 3)) begin
      if (rd) begin
        issue_cmd(rand_cmd(KIND_RX_BYTE), pick_gap());
        issue_cmd(rand_cmd(KIND_TX_ACK), pick_gap());
      end else begin
        issue_cmd(rand_cmd(KIND_TX_BYTE), pick_gap());
        issue_cmd(rand_cmd(KIND_RX_ACK), pick_gap());
      end
    end
    if ($urandom_range(0, 3) != 0) issue_cmd(rand_cmd(KIND_STOP), pick_gap());
  endtask

  initial begin : rx_stall_gen
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : word_check
    line_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (line_word_q.size() == 0) begin
        $display("%0t: unexpected word scl=%0b sda=%0b last=%0b read_value=%0h",
                 $time, out_scl_level, out_sda_level, out_last, out_read_value);
        mismatches++;
      end else begin
        want = line_word_q.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(out_scl_level));
        check_field("sda_level", 8'(want.sda), 8'(out_sda_level));
        check_field("last", 8'(want.last), 8'(out_last));
        check_field("read_value", want.rv, out_read_value);
      end
    end
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("i2c_bit_level_master_unit_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    plan_row_t             row;
    line_word_t            w;
    logic [CFG_DATA_W-1:0] rdata;
    int                    r;
    int                    base;
    int                    progress;
    int                    stage;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = '0;
    in_tx_byte = '0;
    in_ack_out = 1'b0;
    in_sda_samples = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    scl_now = 1'b1;
    sda_now = 1'b1;
    cur_hold = HOLD_RESET;
    stage = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_hold_readback();

    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_PLAN[r];
      if (row.new_hold) begin
        settle_block();
        program_hold(row.hold);
      end
      issue_cmd(row.cmd, pick_gap());
      if (row.typed) begin
        w = line_word_q.pop_back();
        line_word_q.push_back('{scl: row.scl, sda: row.sda, last: 1'b1, rv: row.rv});
      end
    end

    // A write to an address with no register behind it must leave hold_cycles alone.
    settle_block();
    apb_xfer(1'b1, SPARE_ADDR, '1, rdata);
    check_hold_readback();

    base = cmds_taken;
    while (cmds_taken - base < RANDOM_CMDS) begin
      progress = cmds_taken - base;
      if (stage == 0 && progress >= 20) begin
        settle_block();
        program_hold(HOLD_W'($urandom_range(2, 40)));
        stage = 1;
      end else if (stage == 1 && progress >= 32) begin
        rx_hold_req = 1'b1;
        repeat (4) issue_cmd(rand_cmd(KIND_TX_BYTE), 0);
        stage = 2;
      end else if (stage == 2 && progress >= 44) begin
        settle_block();
        program_hold(HOLD_W'($urandom_range(1, 12)));
        stage = 3;
      end else if (stage == 3 && progress >= 52) begin
        in_valid <= 1'b0;
        while (line_word_q.size() != 0) @(posedge clk);
        @(negedge clk);
        stage = 4;
      end else if (stage == 4 && progress >= 64) begin
        quiet = 1'b1;
        stage = 5;
      end
      if ($urandom_range(0, 4) == 0) issue_cmd(rand_cmd(3'($urandom_range(0, 7))), pick_gap());
      else run_bus_transfer();
    end

    settle_block();
    if (mismatches == 0) begin
      $display("i2c_bit_level_master_unit_tb OK");
    end else begin
      $display("i2c_bit_level_master_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
